/* src/pcx_rle_scanline_decoder_core_macros.svh */
// Assertion macros shared by the PCX RLE decoder RTL.
`ifndef PCX_RLE_SCANLINE_DECODER_CORE_MACROS_SVH
`define PCX_RLE_SCANLINE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PCXRLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PCXRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pcxrle_pkg.sv */
// Shared types and constants of the PCX RLE scanline decoder.
`timescale 1ns / 1ps
`default_nettype none
package pcxrle_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  localparam logic [3:0] BITS_24    = 4'd8;
  localparam logic [2:0] PLANES_24  = 3'd3;
  localparam logic [2:0] MAX_PLANES = 3'd4;

  localparam logic [1:0] CNT_MONO = 2'd1;
  localparam logic [1:0] CNT_RGB  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_BYTES_PER_LINE = 3'd2,
    REG_PLANE_COUNT    = 3'd3,
    REG_BITS_PER_PLANE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [14:0] image_width;
    logic [15:0] image_height;
    logic [11:0] bytes_per_plane_line;
    logic [2:0]  plane_count;
    logic [3:0]  bits_per_plane;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input word accepted this cycle
    logic run_step;  // emit one more repeat of the held byte
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_ok;   // output side has room for a decoded byte
    logic more;      // this step leaves repeats still to go
  } dp_status_t;

endpackage
`default_nettype wire

/* src/pcxrle_cfg_regs.sv */
// Configuration register file of the PCX RLE scanline decoder.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_cfg_regs import pcxrle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width          <= 15'd1;
      cfg.image_height         <= 16'd1;
      cfg.bytes_per_plane_line <= 12'd1;
      cfg.plane_count          <= 3'd1;
      cfg.bits_per_plane       <= 4'd8;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:    cfg.image_width          <= cfg_data[14:0];
        REG_IMAGE_HEIGHT:   cfg.image_height         <= cfg_data[15:0];
        REG_BYTES_PER_LINE: cfg.bytes_per_plane_line <= cfg_data[11:0];
        REG_PLANE_COUNT:    cfg.plane_count          <= cfg_data[2:0];
        REG_BITS_PER_PLANE: cfg.bits_per_plane       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/pcxrle_plane_store.sv */
// Line store for planes 0 and 1 in 24-bit mode, registered reads.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_plane_store #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     wr_plane,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data0,
  output logic [7:0]               rd_data1
);

  logic [7:0] mem0 [DEPTH];
  logic [7:0] mem1 [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_plane) begin
      mem0[wr_addr] <= wr_data;
    end
    if (wr_en && wr_plane) begin
      mem1[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data0 <= mem0[rd_addr];
      rd_data1 <= mem1[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/pcxrle_datapath.sv */
// Position, run and line state, store access and output stages.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_datapath import pcxrle_pkg::*; #(
  parameter int MAX_PLANE_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [7:0]  s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  output logic [1:0]  m_tuser
);

`include "pcx_rle_scanline_decoder_core_macros.svh"

  localparam int AW = $clog2(MAX_PLANE_BYTES);

  // state
  logic [13:0] line_position;
  logic        run_pending;
  logic [5:0]  run_length;
  logic [15:0] lines_done;
  logic [7:0]  held_byte;
  logic [5:0]  remaining;

  // derived geometry
  logic [2:0]  planes_eff;
  logic [14:0] bpl1, bpl2, bpl3, line_len;
  logic        is24;
  logic [14:0] w24, last24, last_n, last_sel, n_emit;
  logic [18:0] wb;
  logic [20:0] wbp;
  logic [17:0] nb;

  always_comb begin
    planes_eff = (cfg.plane_count > MAX_PLANES) ? MAX_PLANES : cfg.plane_count;
    bpl1 = 15'(cfg.bytes_per_plane_line);
    bpl2 = bpl1 << 1;
    bpl3 = bpl1 + bpl2;
    unique case (planes_eff)
      3'd1:    line_len = bpl1;
      3'd2:    line_len = bpl2;
      3'd3:    line_len = bpl3;
      3'd4:    line_len = bpl1 << 2;
      default: line_len = 15'd0;
    endcase
    is24 = (cfg.bits_per_plane == BITS_24) && (cfg.plane_count == PLANES_24);
    w24 = (cfg.image_width < bpl1) ? cfg.image_width : bpl1;
    last24 = bpl2 + w24 - 15'd1;
    wb = 19'(cfg.image_width) * 19'(cfg.bits_per_plane);
    unique case (planes_eff)
      3'd1:    wbp = 21'(wb);
      3'd2:    wbp = 21'(wb) << 1;
      3'd3:    wbp = 21'(wb) + (21'(wb) << 1);
      3'd4:    wbp = 21'(wb) << 2;
      default: wbp = 21'd0;
    endcase
    nb = wbp[20:3];
    n_emit = (nb < 18'(line_len)) ? nb[14:0] : line_len;
    last_n = n_emit - 15'd1;
    last_sel = is24 ? last24 : last_n;
  end

  // item decode, with start of image applied first
  logic        clear, blocked, do_step;
  logic [7:0]  byte_cur;
  logic [13:0] pos_e;
  logic [15:0] lines_e;
  logic        pend_e;
  logic [5:0]  rlen_e, count_take, remaining_cur;

  always_comb begin
    clear    = cmd.take && s_tuser[0];
    byte_cur = cmd.take ? s_tdata : held_byte;
    pos_e    = clear ? 14'd0 : line_position;
    lines_e  = clear ? 16'd0 : lines_done;
    pend_e   = clear ? 1'b0 : run_pending;
    rlen_e   = clear ? 6'd0 : run_length;
    blocked  = (cfg.image_height == 16'd0) || (line_len == 15'd0) ||
               (lines_e >= cfg.image_height);
    if (pend_e) begin
      count_take = rlen_e;
    end else if (byte_cur >= RUN_MARK) begin
      count_take = 6'd0;
    end else begin
      count_take = 6'd1;
    end
    remaining_cur = cmd.take ? count_take : remaining;
    do_step = cmd.take ? (!blocked && (count_take != 6'd0)) : cmd.run_step;
  end

  // one decoded byte at pos_e
  logic [14:0] pos15, pos_inc, off15;
  logic        in_p0, in_p1, in_p2, off_fits, emit, wrap, at_last;
  logic        emit_step, step_le, step_ie, step_li;
  logic [16:0] off_ext;
  logic [AW-1:0] mem_addr;

  always_comb begin
    pos15 = 15'(pos_e);
    in_p0 = pos15 < bpl1;
    in_p1 = pos15 < bpl2;
    in_p2 = pos15 < bpl3;
    if (in_p0) begin
      off15 = pos15;
    end else if (in_p1) begin
      off15 = pos15 - bpl1;
    end else begin
      off15 = pos15 - bpl2;
    end
    off_ext  = 17'(off15[11:0]);
    off_fits = off_ext < 17'(MAX_PLANE_BYTES);
    mem_addr = off_ext[AW-1:0];
    emit = is24 ? (!in_p1 && in_p2 && (off15 < w24)) : (pos15 < n_emit);
    pos_inc = pos15 + 15'd1;
    wrap    = pos_inc >= line_len;
    at_last = pos15 == last_sel;
    emit_step = do_step && emit;
    step_le = at_last;
    step_ie = at_last && ((17'(lines_e) + 17'd1) == 17'(cfg.image_height));
    // emitting positions are contiguous, so the word at the end of the
    // emitting span, of the run or of the line closes this input word
    step_li = at_last || (remaining_cur == 6'd1) || wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      run_pending   <= 1'b0;
      run_length    <= '0;
      lines_done    <= '0;
      remaining     <= '0;
    end else begin
      if (cmd.take) begin
        line_position <= pos_e;
        lines_done    <= lines_e;
        run_pending   <= pend_e;
        run_length    <= rlen_e;
        if (!blocked) begin
          if (pend_e) begin
            run_pending <= 1'b0;
          end else if (byte_cur >= RUN_MARK) begin
            run_pending <= 1'b1;
            run_length  <= byte_cur[5:0] & RUN_MASK[5:0];
          end
        end
      end
      if (do_step) begin
        remaining <= remaining_cur - 6'd1;
        if (wrap) begin
          line_position <= '0;
          lines_done    <= lines_e + 16'd1;
        end else begin
          line_position <= pos_inc[13:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held_byte <= s_tdata;
    end
  end

  // store: planes 0/1 written, both read for a plane-2 pixel
  logic [7:0] rd_data0, rd_data1;

  pcxrle_plane_store #(
    .DEPTH (MAX_PLANE_BYTES)
  ) u_store (
    .clk      (clk),
    .wr_en    (do_step && is24 && in_p1 && off_fits),
    .wr_plane (!in_p0),
    .wr_addr  (mem_addr),
    .wr_data  (byte_cur),
    .rd_en    (emit_step && is24),
    .rd_addr  (mem_addr),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // stage 1 waits for the store read; output register behind it
  logic       s1_valid, s1_move, s1_rgb, s1_zero, s1_le, s1_ie, s1_li;
  logic [7:0] s1_byte0;
  logic       out_valid, out_le, out_ie, out_li;
  logic [7:0] out_byte0, out_byte1, out_byte2;
  logic [1:0] out_cnt;

  assign s1_move = s1_valid && (!out_valid || m_tready);
  assign status.step_ok = !s1_valid || s1_move;
  assign status.more = do_step && !wrap && (remaining_cur > 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (emit_step) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_step) begin
      s1_byte0 <= byte_cur;
      s1_rgb   <= is24;
      s1_zero  <= !off_fits;
      s1_le    <= step_le;
      s1_ie    <= step_ie;
      s1_li    <= step_li;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_byte0 <= s1_byte0;
      out_byte1 <= (s1_rgb && !s1_zero) ? rd_data1 : 8'd0;
      out_byte2 <= (s1_rgb && !s1_zero) ? rd_data0 : 8'd0;
      out_cnt   <= s1_rgb ? CNT_RGB : CNT_MONO;
      out_le    <= s1_le;
      out_ie    <= s1_ie;
      out_li    <= s1_li;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_cnt, out_byte2, out_byte1, out_byte0};
  assign m_tlast  = out_le;
  assign m_tuser  = {out_li, out_ie};

  `PCXRLE_ASSERT_NOW(a_step_has_room, clk, rst, emit_step, status.step_ok,
    "decoded word issued with no room in stage 1")
  `PCXRLE_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s1_move, s1_valid,
    "stage 1 word lost while output stalled")
  `PCXRLE_ASSERT_NOW(a_image_end_on_line_end, clk, rst, out_valid && out_ie, out_le,
    "image end flagged on a word that does not end a line")

endmodule
`default_nettype wire

/* src/pcxrle_ctrl.sv */
// Controller: accepts coded words and sequences the repeats of a run.
`timescale 1ns / 1ps
`default_nettype none
module pcxrle_ctrl import pcxrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

`include "pcx_rle_scanline_decoder_core_macros.svh"

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.run_step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = status.step_ok;
        cmd.take = s_tvalid && status.step_ok;
        if (cmd.take && status.more) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run_step = status.step_ok;
        if (cmd.run_step && !status.more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PCXRLE_ASSERT_NOW(a_no_take_in_run, clk, rst, state == ST_RUN, !cmd.take,
    "input word taken while a run is still being expanded")

endmodule
`default_nettype wire

/* src/pcx_rle_scanline_decoder_core.sv */
// Top level of the PCX RLE scanline decoder.
//
// Usage:
//   Slave stream s_*: one coded byte per word. s_tdata[7:0] = coded byte,
//   s_tuser[0] = start of image (clears line, plane and run state first).
//   Master stream m_*: one decoded byte (or one B,G,R pixel in 24-bit mode)
//   per word. m_tlast marks the last word of a scanline.
//   Config port: cfg_wr_en/cfg_index/cfg_data write one register per clock;
//   write only while no word is in flight.
// Throughput: the repeat sequencer in the controller expands a run's value
//   byte, cut at the line end, at one decoded byte per cycle while stage 1
//   has room; no new coded byte is accepted until the run is done.
// Pipeline: accepted words pass stage 1 (store read), then the output reg.
// Stall: stage 1 plus the output register buffer two words; when both are
//   full and m_tready is low, s_tready drops and a run in progress pauses.
// Reset (rst, synchronous): registers return to width 1, height 1, one byte
//   per plane line, one plane, 8 bits; position, run and line counts clear.
//   The plane store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module pcx_rle_scanline_decoder_core import pcxrle_pkg::*; #(
  parameter int MAX_PLANE_BYTES = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  // coded input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] coded_byte
  input  logic [0:0]            s_tuser,   // [0] start_of_image
  // decoded output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [7:0] out_byte0, [15:8] out_byte1,
                                           // [23:16] out_byte2, [25:24] byte_count
  output logic                  m_tlast,   // line_end
  output logic [1:0]            m_tuser,   // [0] image_end, [1] last_of_input
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  pcxrle_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // controller: accept and run sequencing
  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: line state, plane store, output stages
  pcxrle_datapath #(
    .MAX_PLANE_BYTES (MAX_PLANE_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

/* dv/tb_pcx_rle_scanline_decoder_core.sv */
// Self-checking testbench for the PCX RLE scanline decoder core.
`timescale 1ns / 1ps
module tb_pcx_rle_scanline_decoder_core;
  import pcxrle_pkg::*;

  localparam int PLANE_BYTES   = 2048;
  // a run may keep stepping through up to 63 positions that emit nothing after
  // the last predicted word, plus the 2-deep pipeline
  localparam int SETTLE_CYCLES = 72;
  localparam int QUIET_LIMIT   = 1500;  // idle cycles with no handshake before giving up
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_WORDS   = 32;

  // One decoded output word as the block should produce it.
  typedef struct packed {
    logic [7:0] b0;           // decoded byte, or blue
    logic [7:0] b1;           // green in 24-bit mode
    logic [7:0] b2;           // red in 24-bit mode
    logic [1:0] nbytes;
    logic       line_end;
    logic       image_end;
    logic       last_of_byte;
  } dec_word_t;

  // Tracks the decoder's line/run state and the words still owed by the block.
  class scanline_scoreboard;
    logic [14:0] width;
    logic [15:0] height;
    logic [11:0] bpl_reg;
    logic [2:0]  planes_reg;
    logic [3:0]  bits_reg;
    int unsigned line_pos, lines_done, run_len;
    bit          run_wait;
    logic [7:0]  plane_mem [0:2*PLANE_BYTES-1];
    dec_word_t   due_words[$];
    int unsigned mismatches, bytes_seen, words_seen, lines_seen, images_seen;

    function new();
      width = 1;
      height = 1;
      bpl_reg = 1;
      planes_reg = 1;
      bits_reg = 8;
      line_pos = 0;
      lines_done = 0;
      run_len = 0;
      run_wait = 0;
      mismatches = 0;
      bytes_seen = 0;
      words_seen = 0;
      lines_seen = 0;
      images_seen = 0;
      foreach (plane_mem[i]) plane_mem[i] = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:    width = val[14:0];
        REG_IMAGE_HEIGHT:   height = val[15:0];
        REG_BYTES_PER_LINE: bpl_reg = val[11:0];
        REG_PLANE_COUNT:    planes_reg = val[2:0];
        REG_BITS_PER_PLANE: bits_reg = val[3:0];
        default: ;
      endcase
    endfunction

    // True while the decoder drops every byte until the next start of image.
    function bit image_over();
      int unsigned planes;
      planes = (planes_reg > MAX_PLANES) ? 32'(MAX_PLANES) : 32'(planes_reg);
      return (height == 0) || (32'(bpl_reg) * planes == 0) ||
             (lines_done >= 32'(height));
    endfunction

    // Advance the decoder state by one accepted coded byte and queue the
    // words it produces. Returns 0 when the byte is simply dropped.
    function bit take_coded_byte(logic [7:0] b, logic sop);
      int unsigned planes, bpl, line_len, count, n_emit, end_pos, w, nb, pos, p, off, k;
      int unsigned wid, hgt, bits;
      bit is24, has_last, emit;
      dec_word_t wd;
      dec_word_t fresh[$];
      bytes_seen++;
      if (sop) begin
        line_pos = 0;
        run_wait = 0;
        run_len = 0;
        lines_done = 0;
      end
      wid = 32'(width);
      hgt = 32'(height);
      bits = 32'(bits_reg);
      planes = (planes_reg > MAX_PLANES) ? 32'(MAX_PLANES) : 32'(planes_reg);
      bpl = 32'(bpl_reg);
      line_len = bpl * planes;
      if (hgt == 0 || line_len == 0 || lines_done >= hgt) return 0;

      if (run_wait) begin
        count = run_len;
        run_wait = 0;
      end else if (b >= RUN_MARK) begin
        run_wait = 1;
        run_len = 32'(b & RUN_MASK);
        return 1;
      end else begin
        count = 1;
      end

      is24 = (bits_reg == BITS_24) && (planes_reg == PLANES_24);
      w = 0;
      n_emit = 0;
      if (is24) begin
        w = (wid < bpl) ? wid : bpl;
        has_last = (w > 0);
        end_pos = 2 * bpl + w - (has_last ? 1 : 0);
      end else begin
        nb = (wid * bits * planes) >> 3;
        n_emit = (nb < line_len) ? nb : line_len;
        has_last = (n_emit > 0);
        end_pos = has_last ? n_emit - 1 : 0;
      end

      for (k = 0; k < count; k++) begin
        pos = line_pos;
        emit = 0;
        wd = '0;
        wd.b0 = b;
        wd.nbytes = CNT_MONO;
        if (is24) begin
          p = pos / bpl;
          off = pos % bpl;
          if (p < 2) begin
            if (off < PLANE_BYTES) plane_mem[p * PLANE_BYTES + off] = b;
          end else if (p == 2 && off < w) begin
            emit = 1;
            wd.b1 = (off < PLANE_BYTES) ? plane_mem[PLANE_BYTES + off] : 8'h00;
            wd.b2 = (off < PLANE_BYTES) ? plane_mem[off] : 8'h00;
            wd.nbytes = CNT_RGB;
          end
        end else begin
          emit = (pos < n_emit);
        end
        if (emit) begin
          wd.line_end = has_last && (pos == end_pos);
          wd.image_end = wd.line_end && (lines_done + 1 == hgt);
          fresh.push_back(wd);
        end
        line_pos = (pos + 1) & 32'h3FFF;
        if (pos + 1 >= line_len) begin
          // line complete; any repeats left in the run are dropped
          line_pos = 0;
          lines_done = (lines_done + 1) & 32'hFFFF;
          lines_seen++;
          if (lines_done == hgt) images_seen++;
          break;
        end
      end

      if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_byte = 1'b1;
      foreach (fresh[i]) due_words.push_back(fresh[i]);
      return 1;
    endfunction

    task flag(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    endtask

    task match_word(logic [31:0] data, logic tlast, logic [1:0] tuser);
      dec_word_t want;
      if (due_words.size() == 0) begin
        flag("unexpected word", data, 32'd0);
        return;
      end
      want = due_words.pop_front();
      words_seen++;
      if (data[7:0] !== want.b0)
        flag("out_byte0", 32'(data[7:0]), 32'(want.b0));
      if (data[15:8] !== want.b1)
        flag("out_byte1", 32'(data[15:8]), 32'(want.b1));
      if (data[23:16] !== want.b2)
        flag("out_byte2", 32'(data[23:16]), 32'(want.b2));
      if (data[25:24] !== want.nbytes)
        flag("byte_count", 32'(data[25:24]), 32'(want.nbytes));
      if (data[31:26] !== 6'd0)
        flag("tdata pad", 32'(data[31:26]), 32'd0);
      if (tlast !== want.line_end)
        flag("line_end", 32'(tlast), 32'(want.line_end));
      if (tuser[0] !== want.image_end)
        flag("image_end", 32'(tuser[0]), 32'(want.image_end));
      if (tuser[1] !== want.last_of_byte)
        flag("last_of_input", 32'(tuser[1]), 32'(want.last_of_byte));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tlast;
  logic [1:0]            m_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scanline_scoreboard sb;
  int unsigned gap_odds = 0;     // 0: sender never idles, else 1-in-N chance per word
  bit          stall_on = 0;     // receiver back-pressure enable
  int unsigned ready_hold = 0;
  int unsigned quiet = 0;
  int unsigned live_bytes = 0;   // bytes the decoder actually acted on
  int unsigned settings_done = 0;

  pcx_rle_scanline_decoder_core #(
    .MAX_PLANE_BYTES(PLANE_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: stalls come in bursts of random length while enabled.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every decoded word is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_word(m_tdata, m_tlast, m_tuser);
  end

  // Watchdog: the run is hung if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one coded word, optionally after an idle burst; valid stays high
  // after acceptance so back-to-back words need no extra edge.
  task push_byte(logic [7:0] b, logic sop);
    int unsigned gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= sop;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.take_coded_byte(b, sop)) live_bytes++;
  endtask

  task push_run(logic [5:0] reps, logic [7:0] value);
    push_byte(RUN_MARK | {2'b00, reps}, 1'b0);
    push_byte(value, 1'b0);
  endtask

  // Stop sending and wait until every predicted word is out, then let the
  // block finish any repeats that produce nothing.
  task settle_output();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Only called right after settle_output, so the block is idle.
  task load_setting(logic [15:0] w, logic [15:0] h, logic [15:0] bpl,
                    logic [15:0] planes, logic [15:0] bits);
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    put_reg(REG_BYTES_PER_LINE, bpl);
    put_reg(REG_PLANE_COUNT, planes);
    put_reg(REG_BITS_PER_PLANE, bits);
    cfg_wr_en <= 1'b0;
    settings_done++;
  endtask

  // One register setting followed by a stream of coded data. The first few
  // phases pin the extremes; the rest are drawn at random, mostly small.
  task random_phase(int unsigned ph, int unsigned quota);
    int unsigned live_start, sent, kind, r;
    logic [15:0] w, h, bpl, planes, bits;
    logic [7:0] v;
    logic sop;
    bit first;
    case (ph)
      0: begin
        w = 16'd16384; h = 16'd65535; bpl = 16'd2048; planes = 16'd4; bits = 16'd8;
      end
      1: begin
        w = 16'd16384; h = 16'd65535; bpl = 16'd2048; planes = 16'd3; bits = 16'd8;
      end
      2: begin     // line emits nothing
        w = 16'd1; h = 16'd1; bpl = 16'd1; planes = 16'd1; bits = 16'd1;
      end
      3: begin     // everything dropped
        w = 16'd0; h = 16'd0; bpl = 16'd0; planes = 16'd0; bits = 16'd0;
      end
      default: begin
        r = $urandom_range(0, 19);
        w = (r == 0) ? 16'd0 : (r == 1) ? 16'd16384 : (r == 2) ? 16'd32767
                             : 16'($urandom_range(1, 12));
        r = $urandom_range(0, 19);
        h = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 : 16'($urandom_range(1, 3));
        r = $urandom_range(0, 19);
        bpl = (r == 0) ? 16'd0 : (r == 1) ? 16'd2048 : 16'($urandom_range(1, 6));
        planes = ($urandom_range(0, 9) < 4) ? 16'd3 : 16'($urandom_range(0, 7));
        bits = ($urandom_range(0, 1) == 0) ? 16'd8 : 16'($urandom_range(0, 15));
      end
    endcase
    settle_output();
    load_setting(w, h, bpl, planes, bits);
    live_start = live_bytes;
    sent = 0;
    first = 1;
    while (live_bytes - live_start < quota && sent < 2 * quota) begin
      // restart right away on a new setting, and usually once the image is over
      sop = first || (sb.image_over() && $urandom_range(0, 1) == 0) ||
            ($urandom_range(0, 39) == 0);
      first = 0;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        v = 8'($urandom_range(0, 8'hBF));
        push_byte(v, sop);
      end else if (kind < 8) begin
        v = RUN_MARK | 8'($urandom_range(0, 63));
        push_byte(v, sop);
        v = 8'($urandom);
        // a start on the value byte breaks the run apart
        push_byte(v, $urandom_range(0, 24) == 0);
        sent++;
      end else begin
        v = 8'($urandom);
        push_byte(v, sop);
      end
      sent++;
      if ($urandom_range(0, 59) == 0) settle_output();
    end
  endtask

  initial begin
    int unsigned ph;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    gap_odds = 4;
    stall_on = 1;

    // Reset setting: one byte per line, one line per image.
    push_byte(8'h5A, 1'b1);
    push_byte(8'h33, 1'b0);          // past the last line: dropped

    // 24-bit, 4 bytes per plane, 3 pixels wide, 2 lines.
    settle_output();
    load_setting(16'd3, 16'd2, 16'd4, 16'd3, 16'd8);
    push_byte(8'h00, 1'b1);
    push_byte(8'hBF, 1'b0);          // largest literal
    push_run(6'd2, 8'hFF);
    push_run(6'd0, 8'h12);           // zero-length run
    push_run(6'd4, 8'h80);           // fills plane 1
    push_byte(8'h01, 1'b0);          // first pixel
    push_run(6'd63, 8'h7E);          // cut at the line end
    push_run(6'd62, 8'h55);          // whole second line, cut, image end
    push_byte(8'h44, 1'b0);          // ignored after the image
    push_byte(8'hC1, 1'b0);
    push_byte(8'h3A, 1'b1);          // restart

    // More than four planes, 1 bit per plane: two bytes emitted per line.
    settle_output();
    load_setting(16'd5, 16'd1, 16'd2, 16'd7, 16'd1);
    push_byte(8'hC5, 1'b1);
    push_byte(8'h3C, 1'b0);
    push_run(6'd63, 8'hF0);
    push_byte(8'h9C, 1'b0);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph >= RAND_PHASES - 3) begin
        // closing stretch runs at full rate on both sides
        gap_odds = 0;
        stall_on = 0;
      end else begin
        gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      random_phase(ph, (ph < 2) ? 15 : PHASE_WORDS);
    end

    settle_output();
    $display("covered %0d coded words over %0d register settings (24-bit and planar modes)",
             sb.bytes_seen, settings_done);
    $display("checked %0d decoded words, %0d scanlines, %0d full images",
             sb.words_seen, sb.lines_seen, sb.images_seen);
    if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
